// File: rtl/rab_pkg.sv
// ============================================================================
// rab_pkg : shared definitions for the region arena bump allocator
// Sizes, region table geometry, state and status codes, and the write beat
// type used to update one entry of the region table.
// ============================================================================
package rab_pkg;

   // Region table geometry.
   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

   // Sizes are byte counts of a fixed width; alignment is a power of two.
   localparam int SIZE_W      = 32;
   localparam int ALIGN_LOG2  = 4;
   localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;

   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   localparam size_type ALIGN_MASK    = size_type'(ALIGN_BYTES - 1);
   localparam size_type RESET_DEFAULT = size_type'(4096);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_SCAN,
      ST_APPEND,
      ST_RELEASE
   } state_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // One write into the region table: fill always, capacity on request.
   typedef struct packed {
      logic     en;
      logic     cap_en;
      idx_type  addr;
      size_type fill;
      size_type cap;
   } region_wr_type;

endpackage

// File: rtl/rab_add_cmp.sv
// ============================================================================
// rab_add_cmp : shared add and compare unit
// Forms a + b with its carry and tells whether c is at least that sum. The
// sequencer uses it for rounding, for the fit test and for the capacity pick.
// ============================================================================
module rab_add_cmp (
   input  rab_pkg::size_type       op_a,
   input  rab_pkg::size_type       op_b,
   input  rab_pkg::size_type       op_c,
   output logic [rab_pkg::SIZE_W:0] sum,
   output logic                     c_ge_sum
);

   assign sum      = {1'b0, op_a} + {1'b0, op_b};
   assign c_ge_sum = ({1'b0, op_c} >= sum);

endmodule

// File: rtl/region_arena_bump_allocator.sv
// ============================================================================
// region_arena_bump_allocator : first-fit bump allocator over a region chain
// Rounds each request up to the alignment, scans the live regions in creation
// order for room, and appends a new region when none fits. Release drops all
// regions and restarts with one empty region of the default capacity.
// ============================================================================
//
//  Channel   Ports                                   Beat taken when
//  --------  --------------------------------------  -------------------------
//  request   start, busy, req_action, req_alloc_size  start high, busy low
//  response  rsp_valid, rsp_*                         every cycle rsp_valid high
//  csr       csr_wr_en, csr_wr_data                   csr_wr_en high
//
// An allocate first rounds its size up, then scans the live regions in
// creation order until one has room; when none has, it appends a new region,
// or answers table-full once all 16 regions are scanned. A release or an
// overflowing allocate goes straight to its response. The scan speed is set
// by the single add and compare unit, which looks at one region table entry
// per cycle. A beat may be offered in the same cycle that the previous
// response is shown.
// Synchronous reset restores a default capacity of 4096 and one empty region.
// The receiver cannot stall: each response is on the rsp_ ports for exactly one
// cycle.
//
module region_arena_bump_allocator (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [31:0] req_alloc_size,

   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_region_index,
   output logic [31:0] rsp_offset,
   output logic [31:0] rsp_granted_size,
   output logic        rsp_region_created,

   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   // Sequencer state.
   rab_pkg::state_type state_ff, state_in;
   rab_pkg::size_type  size_ff, size_in;
   rab_pkg::size_type  aligned_ff, aligned_in;
   rab_pkg::idx_type   idx_ff, idx_in;
   rab_pkg::cnt_type   count_ff, count_in;
   rab_pkg::size_type  default_ff;

   // Region table: one fill level and one capacity per region. Only entries
   // below the live count are ever read, so the rest need no clearing.
   rab_pkg::size_type  fill_ff [rab_pkg::MAX_REGIONS];
   rab_pkg::size_type  cap_ff  [rab_pkg::MAX_REGIONS];
   rab_pkg::region_wr_type wr;

   // Registered response.
   logic               rsp_valid_ff, rsp_valid_in;
   rab_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [3:0]         rsp_index_ff, rsp_index_in;
   rab_pkg::size_type  rsp_offset_ff, rsp_offset_in;
   rab_pkg::size_type  rsp_granted_ff, rsp_granted_in;
   logic               rsp_created_ff, rsp_created_in;

   // Shared arithmetic unit.
   rab_pkg::size_type       op_a, op_b, op_c;
   logic [rab_pkg::SIZE_W:0] sum;
   logic                    c_ge_sum;

   rab_pkg::size_type  cur_fill, cur_cap;
   logic               last_region;
   logic               table_full;

   rab_add_cmp u_add_cmp (
      .op_a     (op_a),
      .op_b     (op_b),
      .op_c     (op_c),
      .sum      (sum),
      .c_ge_sum (c_ge_sum)
   );

   assign cur_fill    = fill_ff[idx_ff];
   assign cur_cap     = cap_ff[idx_ff];
   assign last_region = ((rab_pkg::cnt_type'(idx_ff) + rab_pkg::cnt_type'(1)) == count_ff);
   assign table_full  = (count_ff == rab_pkg::cnt_type'(rab_pkg::MAX_REGIONS));

   always_comb begin
      state_in       = state_ff;
      size_in        = size_ff;
      aligned_in     = aligned_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rab_pkg::STATUS_OK;
      rsp_index_in   = '0;
      rsp_offset_in  = '0;
      rsp_granted_in = '0;
      rsp_created_in = 1'b0;
      op_a           = '0;
      op_b           = '0;
      op_c           = '0;
      wr             = '0;

      case (state_ff)
         rab_pkg::ST_IDLE: begin
            if (start) begin
               size_in  = req_alloc_size;
               state_in = req_action ? rab_pkg::ST_RELEASE : rab_pkg::ST_ALIGN;
            end
         end

         // Round up: add the alignment minus one and clear the low bits.
         // A carry out means the rounded size does not fit.
         rab_pkg::ST_ALIGN: begin
            op_a = size_ff;
            op_b = rab_pkg::ALIGN_MASK;
            if (sum[rab_pkg::SIZE_W]) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rab_pkg::STATUS_OVERFLOW;
               state_in      = rab_pkg::ST_IDLE;
            end else begin
               aligned_in = sum[rab_pkg::SIZE_W-1:0] & ~rab_pkg::ALIGN_MASK;
               idx_in     = '0;
               state_in   = rab_pkg::ST_SCAN;
            end
         end

         // One region per cycle. Fill never exceeds capacity, so the region
         // has room exactly when capacity >= fill + aligned size.
         rab_pkg::ST_SCAN: begin
            op_a = cur_fill;
            op_b = aligned_ff;
            op_c = cur_cap;
            if (c_ge_sum) begin
               wr.en          = 1'b1;
               wr.addr        = idx_ff;
               wr.fill        = sum[rab_pkg::SIZE_W-1:0];
               rsp_valid_in   = 1'b1;
               rsp_index_in   = 4'(idx_ff);
               rsp_offset_in  = cur_fill;
               rsp_granted_in = aligned_ff;
               state_in       = rab_pkg::ST_IDLE;
            end else if (last_region) begin
               if (table_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rab_pkg::STATUS_FULL;
                  state_in      = rab_pkg::ST_IDLE;
               end else begin
                  state_in = rab_pkg::ST_APPEND;
               end
            end else begin
               idx_in = idx_ff + rab_pkg::idx_type'(1);
            end
         end

         // New region gets max(aligned size, default) and starts full up to
         // the aligned size.
         rab_pkg::ST_APPEND: begin
            op_a           = aligned_ff;
            op_c           = default_ff;
            wr.en          = 1'b1;
            wr.cap_en      = 1'b1;
            wr.addr        = rab_pkg::idx_type'(count_ff);
            wr.fill        = aligned_ff;
            wr.cap         = c_ge_sum ? default_ff : aligned_ff;
            count_in       = count_ff + rab_pkg::cnt_type'(1);
            rsp_valid_in   = 1'b1;
            rsp_index_in   = 4'(count_ff);
            rsp_granted_in = aligned_ff;
            rsp_created_in = 1'b1;
            state_in       = rab_pkg::ST_IDLE;
         end

         rab_pkg::ST_RELEASE: begin
            wr.en        = 1'b1;
            wr.cap_en    = 1'b1;
            wr.addr      = '0;
            wr.fill      = '0;
            wr.cap       = default_ff;
            count_in     = rab_pkg::cnt_type'(1);
            rsp_valid_in = 1'b1;
            state_in     = rab_pkg::ST_IDLE;
         end

         default: begin
            state_in = rab_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rab_pkg::ST_IDLE;
         count_ff     <= rab_pkg::cnt_type'(1);
         default_ff   <= rab_pkg::RESET_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            default_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      size_ff        <= size_in;
      aligned_ff     <= aligned_in;
      idx_ff         <= idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_created_ff <= rsp_created_in;
   end

   // Region table writes. Reset sets up the single empty default region.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff[0] <= '0;
         cap_ff[0]  <= rab_pkg::RESET_DEFAULT;
      end else if (wr.en) begin
         fill_ff[wr.addr] <= wr.fill;
         if (wr.cap_en) begin
            cap_ff[wr.addr] <= wr.cap;
         end
      end
   end

   assign busy               = (state_ff != rab_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_region_index   = rsp_index_ff;
   assign rsp_offset         = rsp_offset_ff;
   assign rsp_granted_size   = rsp_granted_ff;
   assign rsp_region_created = rsp_created_ff;

   // The live region count always stays between one and the table size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= rab_pkg::cnt_type'(rab_pkg::MAX_REGIONS))
      else $error("region count out of range");

   // A response is only shown once the sequencer is back to idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // Error responses carry no allocation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rab_pkg::STATUS_OK |->
         rsp_granted_size == '0 && rsp_offset == '0 && !rsp_region_created)
      else $error("error response carries allocation data");

   // An appended region always lands at offset zero, and the count grows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region_created |->
         rsp_offset == '0 && count_ff == $past(count_ff) + rab_pkg::cnt_type'(1))
      else $error("region append inconsistent");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top : self-checking testbench for region_arena_bump_allocator
// Drives allocate and release beats through the start/busy handshake, keeps
// its own copy of the region table to predict every response, and compares
// each response field by field as it appears on the rsp_ ports. Directed
// tests cover the fresh table, size extremes, the table-full and zero-size
// cases and extreme default capacities; random phases follow with varied
// sender gaps and default capacities.
// ============================================================================
module tb_top;

   // Expected response for one accepted request beat.
   typedef struct {
      rab_pkg::status_type status;
      rab_pkg::idx_type    region;
      rab_pkg::size_type   offset;
      rab_pkg::size_type   granted;
      logic                created;
   } placement_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [31:0] req_alloc_size;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_region_index;
   logic [31:0] rsp_offset;
   logic [31:0] rsp_granted_size;
   logic        rsp_region_created;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   region_arena_bump_allocator uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_alloc_size     (req_alloc_size),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_region_index   (rsp_region_index),
      .rsp_offset         (rsp_offset),
      .rsp_granted_size   (rsp_granted_size),
      .rsp_region_created (rsp_region_created),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Predicted region table. The testbench keeps its own fill and capacity
   // for every region, the live count, and the default capacity register.
   rab_pkg::size_type fill_level [rab_pkg::MAX_REGIONS];
   rab_pkg::size_type capacity   [rab_pkg::MAX_REGIONS];
   int                live_regions;
   rab_pkg::size_type default_cap;

   // Responses still owed by the block, oldest first.
   placement_type placement_q [$];

   int            mismatch_count;
   int            beats_sent;
   int            release_count;
   int            full_count;
   int            overflow_count;
   int            created_count;
   int            csr_writes;

   // ------------------------------------------------------------------------
   // Clock and watchdog.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The whole run ends well before this 5 ms watchdog fires.
   initial begin
      #5_000_000;
      $display("Timeout with %0d responses outstanding", placement_q.size());
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor. Drops every region and starts over with one empty region of
   // the current default capacity, as reset and a release beat both do.
   // ------------------------------------------------------------------------
   function automatic void restart_regions();
      for (int i = 0; i < rab_pkg::MAX_REGIONS; i++) begin
         fill_level[i] = '0;
         capacity[i]   = '0;
      end
      capacity[0]  = default_cap;
      live_regions = 1;
   endfunction

   // Works out the response to one request beat and updates the table.
   function automatic placement_type predict_placement(logic action,
                                                       rab_pkg::size_type size);
      placement_type            p;
      logic [rab_pkg::SIZE_W:0] rounded;
      rab_pkg::size_type        aligned;
      rab_pkg::size_type        room;
      p = '{rab_pkg::STATUS_OK, '0, '0, '0, 1'b0};

      if (action) begin
         restart_regions();
         return p;
      end

      // Round up to the alignment in one extra bit; a carry into the top
      // bit means the rounded size no longer fits in SIZE_W bits.
      rounded = {1'b0, size} + {1'b0, rab_pkg::ALIGN_MASK};
      rounded = rounded & ~{1'b0, rab_pkg::ALIGN_MASK};
      if (rounded[rab_pkg::SIZE_W]) begin
         p.status = rab_pkg::STATUS_OVERFLOW;
         return p;
      end
      aligned = rounded[rab_pkg::SIZE_W-1:0];

      // First fit in creation order. A zero-size request always lands in
      // region 0 at its current fill without moving it.
      for (int i = 0; i < live_regions; i++) begin
         room = (capacity[i] >= fill_level[i]) ? capacity[i] - fill_level[i] : '0;
         if (room >= aligned) begin
            p.region      = rab_pkg::idx_type'(i);
            p.offset      = fill_level[i];
            p.granted     = aligned;
            fill_level[i] = fill_level[i] + aligned;
            return p;
         end
      end

      if (live_regions >= rab_pkg::MAX_REGIONS) begin
         p.status = rab_pkg::STATUS_FULL;
         return p;
      end

      // Append: the new region is at least as large as the request, even when
      // the default capacity is tiny or zero.
      capacity[live_regions]   = (aligned > default_cap) ? aligned : default_cap;
      fill_level[live_regions] = aligned;
      p.region                 = rab_pkg::idx_type'(live_regions);
      p.granted                = aligned;
      p.created                = 1'b1;
      live_regions             = live_regions + 1;
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor. Everything that happens at a rising edge is handled here in one
   // process, in a fixed order: first the response shown in the cycle that
   // just ended is checked, then a register write is applied, then an
   // accepted request beat is predicted. A response can never belong to a
   // beat taken at the same edge, so this order never loses anything.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      if (reset) begin
         default_cap = rab_pkg::RESET_DEFAULT;
         restart_regions();
         placement_q.delete();
      end else begin
         if (rsp_valid) begin
            got = '{rab_pkg::status_type'(rsp_status), rsp_region_index, rsp_offset,
                    rsp_granted_size, rsp_region_created};
            if (placement_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with nothing outstanding: status=%0d idx=%0d",
                           $realtime, got.status, got.region);
            end else begin
               want = placement_q.pop_front();
               if (got.status !== want.status || got.region !== want.region ||
                   got.offset !== want.offset || got.granted !== want.granted ||
                   got.created !== want.created) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch expected status=%0d idx=%0d off=%h grant=%h new=%0d",
                              $realtime, want.status, want.region, want.offset,
                              want.granted, want.created);
                     $display("%0t: mismatch actual   status=%0d idx=%0d off=%h grant=%h new=%0d",
                              $realtime, got.status, got.region, got.offset,
                              got.granted, got.created);
                  end
               end
            end
         end

         if (csr_wr_en)
            default_cap = csr_wr_data;

         if (start && !busy) begin
            want = predict_placement(req_action, req_alloc_size);
            placement_q.push_back(want);
            if (req_action)
               release_count++;
            else if (want.status == rab_pkg::STATUS_FULL)
               full_count++;
            else if (want.status == rab_pkg::STATUS_OVERFLOW)
               overflow_count++;
            else if (want.created)
               created_count++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers. All inputs change at the falling edge with blocking
   // assignments, so the block always samples settled values.
   // ------------------------------------------------------------------------

   // Offers one request beat and holds it until the block takes it. Returns
   // at the falling edge after acceptance with start still high, so a
   // back-to-back beat can follow without start dropping in between.
   task automatic send_beat(input logic action, input rab_pkg::size_type size);
      start          = 1'b1;
      req_action     = action;
      req_alloc_size = size;
      do
         @(posedge clock);
      while (busy);
      beats_sent++;
      @(negedge clock);
   endtask

   // Idles the sender for a random number of cycles; each cycle is idle with
   // the given percentage. The request fields carry noise while idle.
   task automatic pause_sender(input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start          = 1'b0;
         req_action     = $urandom_range(0, 1);
         req_alloc_size = $urandom();
         @(negedge clock);
      end
   endtask

   // Lets every outstanding beat drain and then idles on, so that the
   // block is back in its idle state before the register is touched.
   task automatic wait_idle();
      start = 1'b0;
      while (placement_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_default_capacity(input rab_pkg::size_type value);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      csr_writes++;
   endtask

   // ------------------------------------------------------------------------
   // Directed tests.
   // ------------------------------------------------------------------------

   // Fresh table after reset: a one-byte request rounds up to one alignment
   // unit, the next request fills region 0 exactly, and the one after that
   // finds no room and appends region 1.
   task automatic test_fresh_region();
      send_beat(1'b0, 32'd1);
      send_beat(1'b0, 32'd4080);
      send_beat(1'b0, 32'd16);
   endtask

   // Largest size that still rounds into range, the two that overflow, and a
   // small request that goes back to an earlier region with room.
   task automatic test_size_extremes();
      send_beat(1'b0, 32'hFFFF_FFF0);
      send_beat(1'b0, 32'hFFFF_FFF1);
      send_beat(1'b0, 32'hFFFF_FFFF);
      send_beat(1'b0, 32'd100);
      send_beat(1'b1, 32'hFFFF_FFFF);
   endtask

   // With a default capacity of zero, region 0 can only take zero-size
   // requests, and every 16-byte request appends a region until the table
   // is full. Then the zero-size case lands in region 0 at offset 0.
   task automatic test_table_full();
      set_default_capacity(32'd0);
      send_beat(1'b1, 32'd0);
      for (int i = 1; i < rab_pkg::MAX_REGIONS; i++)
         send_beat(1'b0, 32'd16);
      send_beat(1'b0, 32'd16);
      send_beat(1'b0, 32'd0);
   endtask

   // Largest default: a release builds region 0 with the full capacity, and
   // a huge request fits in it.
   task automatic test_huge_default();
      set_default_capacity(32'hFFFF_FFFF);
      send_beat(1'b1, 32'd0);
      send_beat(1'b0, 32'h8000_0000);
   endtask

   // ------------------------------------------------------------------------
   // Random traffic. Each phase sets a default capacity and releases so that
   // the table starts from it. Sizes are mostly small so regions fill up and
   // the table runs full, with some full-range and near-overflow sizes, and
   // an occasional release to start the chain over.
   // ------------------------------------------------------------------------
   task automatic test_random_traffic(input int beats, input int idle_pct,
                                      input rab_pkg::size_type default_value);
      int                pick;
      rab_pkg::size_type size;
      set_default_capacity(default_value);
      send_beat(1'b1, $urandom());
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)
            size = $urandom_range(0, 64);
         else if (pick < 60)
            size = $urandom_range(0, 5000);
         else if (pick < 72)
            size = rab_pkg::size_type'($urandom_range(0, 300) * rab_pkg::ALIGN_BYTES);
         else if (pick < 85)
            size = $urandom();
         else
            size = $urandom_range(32'hFFFF_FFE0, 32'hFFFF_FFFF);
         send_beat($urandom_range(0, 99) < 3, size);
         pause_sender(idle_pct);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      int leftover;
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = 1'b0;
      req_alloc_size = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      mismatch_count = 0;
      beats_sent     = 0;
      release_count  = 0;
      full_count     = 0;
      overflow_count = 0;
      created_count  = 0;
      csr_writes     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_fresh_region();
      test_size_extremes();
      test_table_full();
      test_huge_default();

      // Sender behavior cycles through back-to-back beats, a mostly idle
      // sender, and a lightly idle one; defaults include both extremes.
      test_random_traffic(170, 0, 32'd16);
      test_random_traffic(170, 83, rab_pkg::RESET_DEFAULT);
      test_random_traffic(170, 10, 32'd0);
      test_random_traffic(170, 0, 32'hFFFF_FFFF);
      test_random_traffic(170, 83, $urandom_range(16, 8192));
      test_random_traffic(170, 10, 32'd256);

      // Drain: wait for every outstanding response, with a generous bound.
      start = 1'b0;
      for (int k = 0; k < 4000 && placement_q.size() != 0; k++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      leftover = placement_q.size();
      if (leftover != 0)
         $display("%0d expected responses never arrived", leftover);

      $display("Sent %0d request beats over %0d default-capacity writes.",
               beats_sent, csr_writes);
      $display("Saw %0d releases, %0d appends, %0d table-full, %0d overflow responses.",
               release_count, created_count, full_count, overflow_count);
      if (mismatch_count == 0 && leftover == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
